### sv/ldf_pkg.sv
// Shared types, constants and the byte classifier of the log sector deframer.
// Used by every module of the block; depends on nothing.
package ldf_pkg;

  // Sector framing constants
  localparam int unsigned MaxSectorBytes = 4096;
  localparam int unsigned PreSkip        = 10;
  localparam int unsigned PostSkip       = 5;

  localparam int unsigned CountW = 13;
  localparam int unsigned SkipW  = 4;

  // Queue depths
  localparam int unsigned InDepth  = 4;
  localparam int unsigned InPtrW   = $clog2(InDepth);
  localparam int unsigned InCntW   = $clog2(InDepth + 1);
  localparam int unsigned OutDepth = 2;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  localparam logic [7:0] ChE = 8'h45;
  localparam logic [7:0] ChN = 8'h4E;
  localparam logic [7:0] ChD = 8'h44;

  localparam logic KindPayload = 1'b0;
  localparam logic KindDone    = 1'b1;

  // Class of one received byte with respect to the end marker
  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_E     = 2'd1,
    CLS_N     = 2'd2,
    CLS_D     = 2'd3
  } ldf_cls_e;

  // Deframer phase, one-hot
  typedef enum logic [2:0] {
    PH_DATA  = 3'b001,
    PH_TRAIL = 3'b010,
    PH_POST  = 3'b100
  } ldf_phase_e;

  typedef struct packed {
    logic [7:0] data;
    ldf_cls_e   cls;
  } ldf_item_t;

  typedef struct packed {
    logic      valid;
    ldf_item_t item;
  } ldf_qwr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ldf_qstat_t;

  typedef struct packed {
    logic              result_kind;
    logic [7:0]        payload_byte;
    logic [CountW-1:0] sector_length;
    logic              checksum_ok;
    logic              overflow;
  } ldf_result_t;

  function automatic ldf_cls_e classify(input logic [7:0] b);
    ldf_cls_e c;
    unique case (b)
      ChE:     c = CLS_E;
      ChN:     c = CLS_N;
      ChD:     c = CLS_D;
      default: c = CLS_OTHER;
    endcase
    return c;
  endfunction

endpackage

### sv/ldf_queue.sv
// Short queue of classified bytes between the front and back parts.
// Depends on ldf_pkg for the item type and depth.
module ldf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ldf_pkg::ldf_qwr_t  wr_i,
  input  logic               rd_i,
  output ldf_pkg::ldf_qstat_t stat_o,
  output ldf_pkg::ldf_item_t head_o
);
  import ldf_pkg::*;

  ldf_item_t          mem_q [InDepth];
  logic [InPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [InPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [InCntW-1:0]  cnt_q, cnt_d;
  logic               do_wr, do_rd;

  assign stat_o.full  = (cnt_q == InCntW'(InDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  assign do_wr = wr_i.valid && !stat_o.full;
  assign do_rd = rd_i && !stat_o.empty;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == InPtrW'(InDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == InPtrW'(InDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the written item
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_i.item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= InCntW'(InDepth))
    else $error("input queue count beyond depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("input queue count did not advance on write");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.empty |-> (wr_ptr_q == rd_ptr_q))
    else $error("input queue pointers differ while empty");

endmodule

### sv/ldf_front.sv
// Front part: accepts received bytes and tags them with their end-marker class.
// Depends on ldf_pkg for the classifier and the queue write type.
module ldf_front (
  input  logic                push,
  input  logic [7:0]          rx_byte_i,
  input  ldf_pkg::ldf_qstat_t qstat_i,
  output logic                full,
  output ldf_pkg::ldf_qwr_t   wr_o
);
  import ldf_pkg::*;

  // Accept while the queue has room and classify the byte
  assign full           = qstat_i.full;
  assign wr_o.valid     = push && !qstat_i.full;
  assign wr_o.item.data = rx_byte_i;
  assign wr_o.item.cls  = classify(rx_byte_i);

endmodule

### sv/ldf_back.sv
// Back part: runs the sector phase machine on queued bytes and buffers results.
// Depends on ldf_pkg for types, framing constants and depths.
module ldf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ldf_pkg::ldf_qstat_t qstat_i,
  input  ldf_pkg::ldf_item_t  head_i,
  output logic                rd_o,
  input  logic                pop,
  output logic                empty,
  output ldf_pkg::ldf_result_t res_o
);
  import ldf_pkg::*;

  ldf_phase_e         phase_q, phase_d;
  logic [7:0]         prior_q, prior_d, older_q, older_d;
  ldf_cls_e           prior_cls_q, prior_cls_d, older_cls_q, older_cls_d;
  logic [7:0]         xor_q, xor_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [SkipW-1:0]   skip_q, skip_d, skip_inc;
  logic               match_q, match_d, ovf_q, ovf_d;

  ldf_result_t        obuf_q [OutDepth];
  logic [OutPtrW-1:0] owr_q, ord_q;
  logic [OutCntW-1:0] ocnt_q, ocnt_d;

  logic               step, emit, done, do_pop, chk_match;
  ldf_result_t        res_new;

  assign step     = !qstat_i.empty && (ocnt_q != OutCntW'(OutDepth));
  assign rd_o     = step;
  assign skip_inc = skip_q + 1'b1;
  assign chk_match = (head_i.data == xor_q);

  // Phase machine: one queued byte per step
  always_comb begin
    phase_d     = phase_q;
    prior_d     = prior_q;
    older_d     = older_q;
    prior_cls_d = prior_cls_q;
    older_cls_d = older_cls_q;
    xor_d       = xor_q;
    count_d     = count_q;
    skip_d      = skip_q;
    match_d     = match_q;
    ovf_d       = ovf_q;
    emit        = 1'b0;
    done        = 1'b0;
    res_new     = '0;
    if (step) begin
      unique case (phase_q)
        PH_TRAIL: begin
          if (skip_q < SkipW'(PreSkip)) begin
            skip_d = skip_inc;
          end else begin
            match_d = chk_match;
            skip_d  = '0;
            phase_d = PH_POST;
            if (PostSkip == 0) begin
              done = 1'b1;
            end
          end
        end
        PH_POST: begin
          skip_d = skip_inc;
          if (skip_inc >= SkipW'(PostSkip)) begin
            done = 1'b1;
          end
        end
        default: begin
          if (skip_q >= SkipW'(2) && older_cls_q == CLS_E && prior_cls_q == CLS_N &&
              head_i.cls == CLS_D) begin
            // End marker: take E and N back out of the checksum
            xor_d   = xor_q ^ ChN ^ ChE;
            phase_d = PH_TRAIL;
            skip_d  = '0;
          end else begin
            if (skip_q >= SkipW'(2)) begin
              if (count_q >= CountW'(MaxSectorBytes)) begin
                ovf_d = 1'b1;
              end else begin
                emit                 = 1'b1;
                res_new.result_kind  = KindPayload;
                res_new.payload_byte = older_q;
                count_d              = count_q + 1'b1;
              end
            end else begin
              skip_d = skip_inc;
            end
            xor_d       = xor_q ^ head_i.data;
            older_d     = prior_q;
            older_cls_d = prior_cls_q;
            prior_d     = head_i.data;
            prior_cls_d = head_i.cls;
          end
        end
      endcase
      // Report the sector and clear for the next one
      if (done) begin
        emit                  = 1'b1;
        res_new.result_kind   = KindDone;
        res_new.sector_length = count_q;
        res_new.checksum_ok   = (phase_q == PH_TRAIL) ? chk_match : match_q;
        res_new.overflow      = ovf_q;
        phase_d     = PH_DATA;
        prior_d     = '0;
        older_d     = '0;
        prior_cls_d = CLS_OTHER;
        older_cls_d = CLS_OTHER;
        xor_d       = '0;
        count_d     = '0;
        skip_d      = '0;
        match_d     = 1'b0;
        ovf_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DATA;
      prior_q     <= '0;
      older_q     <= '0;
      prior_cls_q <= CLS_OTHER;
      older_cls_q <= CLS_OTHER;
      xor_q       <= '0;
      count_q     <= '0;
      skip_q      <= '0;
      match_q     <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      prior_q     <= prior_d;
      older_q     <= older_d;
      prior_cls_q <= prior_cls_d;
      older_cls_q <= older_cls_d;
      xor_q       <= xor_d;
      count_q     <= count_d;
      skip_q      <= skip_d;
      match_q     <= match_d;
      ovf_q       <= ovf_d;
    end
  end

  // Result buffer: hold results until popped
  assign empty  = (ocnt_q == '0);
  assign do_pop = pop && !empty;
  assign res_o  = obuf_q[ord_q];

  always_comb begin
    ocnt_d = ocnt_q;
    if (emit && !do_pop) begin
      ocnt_d = ocnt_q + 1'b1;
    end else if (!emit && do_pop) begin
      ocnt_d = ocnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      ocnt_q <= ocnt_d;
      if (emit) begin
        owr_q <= (owr_q == OutPtrW'(OutDepth - 1)) ? '0 : owr_q + 1'b1;
      end
      if (do_pop) begin
        ord_q <= (ord_q == OutPtrW'(OutDepth - 1)) ? '0 : ord_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      obuf_q[owr_q] <= res_new;
    end
  end

  a_obuf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= OutCntW'(OutDepth))
    else $error("result buffer count beyond depth");

  a_hist_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (skip_q <= SkipW'(2)))
    else $error("history fill beyond two in data phase");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxSectorBytes))
    else $error("payload count beyond maximum");

  a_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (phase_q == PH_DATA && xor_q == '0 && count_q == '0 && !ovf_q))
    else $error("sector state not cleared after done");

endmodule

### sv/log_sector_deframer_core.sv
// Top level of the log sector deframer: queue-style ports around front and back.
// Depends on ldf_pkg, ldf_front, ldf_queue and ldf_back.
//
// Push one received byte per cycle while full is low; results come out in
// order while empty is low and leave on pop. The phase machine in the back
// part takes one queued byte per cycle while the result buffer has room,
// needing only byte compares and one XOR. A byte passes the front into
// the four-entry byte queue, and its result, if any, is registered in the
// result buffer and shown on the result ports until it is popped;
// a payload byte is emitted for the byte two positions earlier in the stream.
// The two-entry result buffer lets bytes keep flowing while a result waits.
// When the sector ends (E, N, D, ten trailer bytes, the checksum byte and five
// more bytes), one done result carries the saturating payload length, the
// checksum match and the overflow flag, and the block is clean for the next
// sector. Reset clears all control state; no clearing pass is needed.
module log_sector_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [12:0] sector_length_o,
  output logic        checksum_ok_o,
  output logic        overflow_o
);
  import ldf_pkg::*;

  ldf_qwr_t    qwr;
  ldf_qstat_t  qstat;
  ldf_item_t   qhead;
  logic        qrd;
  ldf_result_t res;

  ldf_front u_front (
    .push      (push),
    .rx_byte_i (rx_byte_i),
    .qstat_i   (qstat),
    .full      (full),
    .wr_o      (qwr)
  );

  ldf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (qwr),
    .rd_i   (qrd),
    .stat_o (qstat),
    .head_o (qhead)
  );

  ldf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qstat_i (qstat),
    .head_i  (qhead),
    .rd_o    (qrd),
    .pop     (pop),
    .empty   (empty),
    .res_o   (res)
  );

  // Drive the result fields
  assign result_kind_o   = res.result_kind;
  assign payload_byte_o  = res.payload_byte;
  assign sector_length_o = res.sector_length;
  assign checksum_ok_o   = res.checksum_ok;
  assign overflow_o      = res.overflow;

endmodule

### tb/ldf_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the log sector deframer: watches the byte and result request
// channels, predicts every result from the accepted bytes and compares them.
// Depends on ldf_pkg for the result layout, phases and framing constants.
module ldf_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic                      full_i,
  input  logic [7:0]                rx_byte_i,
  input  logic                      empty_i,
  input  logic                      pop_i,
  input  logic                      result_kind_i,
  input  logic [7:0]                payload_byte_i,
  input  logic [ldf_pkg::CountW-1:0] sector_length_i,
  input  logic                      checksum_ok_i,
  input  logic                      overflow_i,
  output int                        error_count_o,
  output int                        pending_o
);
  import ldf_pkg::*;

  // Predicted deframer state
  ldf_phase_e        sec_phase;
  logic [7:0]        last_byte;
  logic [7:0]        second_byte;
  logic [7:0]        xor_acc;
  logic [CountW-1:0] payload_count;
  logic [SkipW-1:0]  skip_cnt;
  logic              match_bit;
  logic              ovf_bit;

  ldf_result_t expected_q[$];
  int          mismatch_count = 0;

  assign error_count_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Return to the data phase with an empty history
  task automatic clear_sector();
    sec_phase     = PH_DATA;
    last_byte     = '0;
    second_byte   = '0;
    xor_acc       = '0;
    payload_count = '0;
    skip_cnt      = '0;
    match_bit     = 1'b0;
    ovf_bit       = 1'b0;
  endtask

  task automatic emit_done();
    ldf_result_t r;
    r               = '0;
    r.result_kind   = KindDone;
    r.sector_length = payload_count;
    r.checksum_ok   = match_bit;
    r.overflow      = ovf_bit;
    expected_q.push_back(r);
    clear_sector();
  endtask

  // Advance the predicted state by one received byte
  task automatic predict_byte(input logic [7:0] c);
    ldf_result_t r;
    case (sec_phase)
      PH_TRAIL: begin
        if (skip_cnt < PreSkip) begin
          skip_cnt = skip_cnt + 1'b1;
        end else begin
          match_bit = (c == xor_acc);
          skip_cnt  = '0;
          sec_phase = PH_POST;
          if (PostSkip == 0) emit_done();
        end
      end
      PH_POST: begin
        skip_cnt = skip_cnt + 1'b1;
        if (skip_cnt >= PostSkip) emit_done();
      end
      default: begin
        if (skip_cnt >= 2 && second_byte == ChE && last_byte == ChN && c == ChD) begin
          // end marker: take E and N back out of the checksum
          xor_acc   = xor_acc ^ ChN ^ ChE;
          sec_phase = PH_TRAIL;
          skip_cnt  = '0;
        end else begin
          if (skip_cnt >= 2) begin
            if (payload_count >= MaxSectorBytes) begin
              ovf_bit = 1'b1;
            end else begin
              r              = '0;
              r.result_kind  = KindPayload;
              r.payload_byte = second_byte;
              expected_q.push_back(r);
              payload_count = payload_count + 1'b1;
            end
          end else begin
            skip_cnt = skip_cnt + 1'b1;
          end
          xor_acc     = xor_acc ^ c;
          second_byte = last_byte;
          last_byte   = c;
        end
      end
    endcase
  endtask

  // Compare one accepted result with the oldest prediction
  task automatic check_result();
    ldf_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected (kind %0d byte %02h len %0d)",
                                result_kind_i, payload_byte_i, sector_length_i));
      return;
    end
    want = expected_q.pop_front();
    if (result_kind_i !== want.result_kind)
      report_mismatch($sformatf("result_kind %0d, expected %0d",
                                result_kind_i, want.result_kind));
    if (payload_byte_i !== want.payload_byte)
      report_mismatch($sformatf("payload_byte %02h, expected %02h",
                                payload_byte_i, want.payload_byte));
    if (sector_length_i !== want.sector_length)
      report_mismatch($sformatf("sector_length %0d, expected %0d",
                                sector_length_i, want.sector_length));
    if (checksum_ok_i !== want.checksum_ok)
      report_mismatch($sformatf("checksum_ok %0d, expected %0d",
                                checksum_ok_i, want.checksum_ok));
    if (overflow_i !== want.overflow)
      report_mismatch($sformatf("overflow %0d, expected %0d", overflow_i, want.overflow));
  endtask

  // Predict on every accepted byte, check on every accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_sector();
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (push_i && !full_i) predict_byte(rx_byte_i);
      if (pop_i && !empty_i) check_result();
      pending_o <= expected_q.size();
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Top of the log sector deframer testbench: drives sectors of bytes and pops
// results with random gaps; depends on ldf_pkg, ldf_checker and the block.
module tb;
  import ldf_pkg::*;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              push    = 1'b0;
  logic [7:0]        rx_byte = '0;
  logic              pop     = 1'b0;
  logic              full;
  logic              empty;
  logic              result_kind;
  logic [7:0]        payload_byte;
  logic [CountW-1:0] sector_length;
  logic              checksum_ok;
  logic              overflow;
  int                fail_count;
  int                pending_count;

  logic [7:0] sector_body[$];
  int         bytes_sent    = 0;
  int         results_taken = 0;
  bit         send_steady   = 1'b0;
  bit         rcv_steady    = 1'b0;
  bit         held_off      = 1'b0;

  log_sector_deframer_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .rx_byte_i      (rx_byte),
    .empty          (empty),
    .pop            (pop),
    .result_kind_o  (result_kind),
    .payload_byte_o (payload_byte),
    .sector_length_o(sector_length),
    .checksum_ok_o  (checksum_ok),
    .overflow_o     (overflow)
  );

  ldf_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .rx_byte_i      (rx_byte),
    .empty_i        (empty),
    .pop_i          (pop),
    .result_kind_i  (result_kind),
    .payload_byte_i (payload_byte),
    .sector_length_i(sector_length),
    .checksum_ok_i  (checksum_ok),
    .overflow_i     (overflow),
    .error_count_o  (fail_count),
    .pending_o      (pending_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Payload bytes lean on the marker letters to build broken end sequences
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) >= 8) begin
      case ($urandom_range(0, 2))
        0:       b = ChE;
        1:       b = ChN;
        default: b = ChD;
      endcase
    end
    return b;
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, 6);
    if (r < 80) return $urandom_range(7, 40);
    if (r < 97) return $urandom_range(41, 200);
    return $urandom_range(201, 700);
  endfunction

  // Offer one byte and hold it until the block takes the request
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = send_steady ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    rx_byte <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Send sector_body, the end marker, trailer, checksum and closing bytes
  task automatic send_sector(input bit good_sum);
    logic [7:0] acc;
    logic [7:0] sum;
    acc = '0;
    foreach (sector_body[i]) begin
      acc = acc ^ sector_body[i];
      send_byte(sector_body[i]);
    end
    send_byte(ChE);
    send_byte(ChN);
    send_byte(ChD);
    repeat (PreSkip) send_byte(pick_byte());
    sum = 8'($urandom_range(0, 255));
    send_byte(good_sum ? acc : sum);
    repeat (PostSkip) send_byte(pick_byte());
  endtask

  // Stop offering until every predicted result has been popped
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  // Result side: random pops, steady stretches and one long hold-off
  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held_off && results_taken >= 150) begin
        pop <= 1'b0;
        repeat (300) @(posedge clk_i);
        held_off = 1'b1;
      end
      gap = rcv_steady ? 0 : pick_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      results_taken++;
      if (results_taken % 50 == 0) rcv_steady = ($urandom_range(0, 3) == 0);
    end
  end

  // Byte side: directed sector, random sectors with one overflow sector
  initial begin
    int goal;
    int start_count;
    int len;
    int drain_cycles;
    bit big_done;
    logic [7:0] b;
    big_done = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extreme bytes in a short sector, history fill on the first two
    send_steady = 1'b1;
    sector_body.delete();
    sector_body.push_back(8'hFF);
    sector_body.push_back(8'h00);
    sector_body.push_back(8'hFF);
    send_sector(1'b1);
    wait_drained();

    start_count = bytes_sent;
    goal        = 1950;
    while (bytes_sent - start_count < goal) begin
      send_steady = ($urandom_range(0, 3) == 0);
      sector_body.delete();
      if (!big_done && bytes_sent - start_count > goal / 2) begin
        // payload past the maximum: count saturates, overflow is flagged
        len = MaxSectorBytes + 2;
        repeat (len) begin
          b = 8'($urandom_range(0, 255));
          sector_body.push_back(b);
        end
        goal += len + PreSkip + PostSkip + 4;
        send_sector(1'b1);
        big_done = 1'b1;
        wait_drained();
      end else begin
        len = pick_length();
        repeat (len) sector_body.push_back(pick_byte());
        send_sector($urandom_range(0, 3) != 0);
      end
    end
    push <= 1'b0;

    // drain, then give the pipeline time to show any stray result
    drain_cycles = 0;
    @(posedge clk_i);
    while (pending_count != 0 && drain_cycles < 5000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
